// File: hdl/gdad_pkg.sv
package gdad_pkg;

	// Width of the day offset that is honoured; taken from the low bits of the
	// offset field and sign-extended. Valid for 8..16 with a 16-bit port.
	localparam int OFFSET_BITS = 16;
	// Remaining-days counter: one guard bit above the offset.
	localparam int REM_W = OFFSET_BITS + 1;

	localparam logic [15:0] FIRST_YEAR = 16'd1582;
	localparam logic [15:0] YEAR_MAX = 16'hFFFF;
	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_DEC = 4'd12;
	localparam logic [4:0] DAYS_LONG = 5'd31;
	localparam logic [8:0] Y400_LAST = 9'd399;

	// floor(y / 400) for 16-bit y as (y * RECIP_400) >> RECIP_SHIFT, exact.
	localparam int RECIP_SHIFT = 26;
	localparam logic [17:0] RECIP_400 = 18'(((64'd1 << RECIP_SHIFT) + 64'd399) / 64'd400);
	localparam int QUOT_W = 8;

	typedef struct packed {
		logic [4:0]        in_day;
		logic [3:0]        in_month;
		logic [15:0]       in_year;
		logic signed [15:0] offset;
	} req_t;

	typedef struct packed {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [15:0] out_year;
		logic        date_ok;
		logic        year_overflow;
	} rsp_t;

	// Working date plus the days still to move.
	typedef struct packed {
		logic [4:0]              day;
		logic [3:0]              month;
		logic [15:0]             year;
		logic [8:0]              y400;
		logic signed [REM_W-1:0] rem;
	} cursor_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} step_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUOT,
		ST_REM,
		ST_CHECK,
		ST_STEP
	} state_t;

	// Leap test from the year modulo 400.
	function automatic logic is_leap(input logic [8:0] y400);
		return (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200) &&
			(y400 != 9'd300);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// File: hdl/gdad_step.sv
// One month step: either the remaining offset lands inside the current
// month, or the cursor moves to the next/previous month boundary.
module gdad_step import gdad_pkg::*; (
	input  cursor_t     cur,
	output cursor_t     nxt,
	output step_flags_t flags
);

	logic                    leap;
	logic [4:0]              len;
	logic [4:0]              left;
	logic signed [REM_W-1:0] left_s;
	logic signed [REM_W-1:0] day_s;
	logic signed [REM_W-1:0] back_sum;

	assign leap     = is_leap(cur.y400);
	assign len      = month_len(cur.month, leap);
	assign left     = len - cur.day;
	assign left_s   = $signed(REM_W'(left));
	assign day_s    = $signed(REM_W'(cur.day));
	assign back_sum = cur.rem + day_s;

	always_comb begin
		nxt   = cur;
		flags = '0;
		if (!cur.rem[REM_W-1]) begin
			if (cur.rem <= left_s) begin
				nxt.day    = cur.day + cur.rem[4:0];
				flags.done = 1'b1;
			end else begin
				// skip to the 1st of the following month
				nxt.rem = cur.rem - left_s - $signed(REM_W'(1));
				nxt.day = 5'd1;
				if (cur.month == MON_DEC) begin
					nxt.month = MON_JAN;
					if (cur.year == YEAR_MAX) begin
						flags.ovf = 1'b1;
					end else begin
						nxt.year = cur.year + 16'd1;
						nxt.y400 = (cur.y400 == Y400_LAST) ? 9'd0 : cur.y400 + 9'd1;
					end
				end else begin
					nxt.month = cur.month + 4'd1;
				end
			end
		end else begin
			if (back_sum > $signed(REM_W'(0))) begin
				nxt.day    = cur.day + cur.rem[4:0];
				flags.done = 1'b1;
			end else begin
				// back to the last day of the previous month
				nxt.rem = back_sum;
				if (cur.month == MON_JAN) begin
					nxt.month = MON_DEC;
					nxt.day   = DAYS_LONG;
					if (cur.year == 16'd0) begin
						flags.ovf = 1'b1;
					end else begin
						nxt.year = cur.year - 16'd1;
						nxt.y400 = (cur.y400 == 9'd0) ? Y400_LAST : cur.y400 - 9'd1;
					end
				end else begin
					// year unchanged, so the current leap flag holds for February
					nxt.month = cur.month - 4'd1;
					nxt.day   = month_len(cur.month - 4'd1, leap);
				end
			end
		end
	end

endmodule

// File: hdl/gregorian_date_add_days.sv
// Channel   Handshake              Payload  Notes
// request   start, busy            req      taken when start high and busy low
// result    done (one-cycle pulse) rsp      receiver cannot hold it off
//
// After acceptance the request passes through ST_QUOT, ST_REM and ST_CHECK,
// which compute year mod 400 (reciprocal multiply, then remainder) and check
// the date; a valid date then stays in ST_STEP, which applies the month-step
// unit once per cycle until the offset is used up or the year overflows.
// busy is low again in the cycle of done,
// so the next request may be taken there. Asynchronous active-low reset
// clears the sequencer and the strobe only.
module gregorian_date_add_days import gdad_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	state_t      state_q, state_d;
	req_t        item_q;
	cursor_t     cur_q;
	cursor_t     cur_nxt;
	step_flags_t flags;
	logic [QUOT_W-1:0] quot_q;
	rsp_t        rsp_q;
	logic        done_q;

	// control decoded from the state
	logic        accept;
	logic        date_valid;
	logic        finish;

	// validation terms
	logic [33:0] quot_prod;
	logic [15:0] quot_x400;
	logic [15:0] y_rem;
	logic [4:0]  start_len;

	gdad_step u_step (
		.cur   (cur_q),
		.nxt   (cur_nxt),
		.flags (flags)
	);

	assign quot_prod = item_q.in_year * RECIP_400;
	assign quot_x400 = 16'(quot_q) * 16'd400;
	assign y_rem     = item_q.in_year - quot_x400;
	assign start_len = month_len(item_q.in_month, is_leap(cur_q.y400));
	assign date_valid = (item_q.in_year >= FIRST_YEAR) && (item_q.in_day != 5'd0) &&
		(item_q.in_day <= start_len);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_QUOT;
			ST_QUOT:  state_d = ST_REM;
			ST_REM:   state_d = ST_CHECK;
			ST_CHECK: state_d = date_valid ? ST_STEP : ST_IDLE;
			ST_STEP:  if (flags.done || flags.ovf) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy   = 1'b1;
		accept = 1'b0;
		finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			ST_CHECK: finish = !date_valid;
			ST_STEP:  finish = flags.done || flags.ovf;
			default: begin
				busy   = 1'b1;
				accept = 1'b0;
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q      <= req;
			cur_q.day   <= req.in_day;
			cur_q.month <= req.in_month;
			cur_q.year  <= req.in_year;
			// sign-extend from the top honoured offset bit
			cur_q.rem   <= $signed({req.offset[OFFSET_BITS-1], req.offset[OFFSET_BITS-1:0]});
		end
		if (state_q == ST_QUOT) begin
			quot_q <= quot_prod[RECIP_SHIFT +: QUOT_W];
		end
		if (state_q == ST_REM) begin
			cur_q.y400 <= y_rem[8:0];
		end
		if (state_q == ST_STEP) begin
			cur_q <= cur_nxt;
		end
		if (finish) begin
			rsp_q.date_ok       <= (state_q == ST_STEP);
			rsp_q.year_overflow <= (state_q == ST_STEP) && flags.ovf;
			if ((state_q == ST_STEP) && !flags.ovf) begin
				rsp_q.out_day   <= cur_nxt.day;
				rsp_q.out_month <= cur_nxt.month;
				rsp_q.out_year  <= cur_nxt.year;
			end else begin
				// echo: invalid date or year out of range
				rsp_q.out_day   <= item_q.in_day;
				rsp_q.out_month <= item_q.in_month;
				rsp_q.out_year  <= item_q.in_year;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request did not raise busy");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("transaction ended without a result");

	a_ovf_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.year_overflow) |-> rsp.date_ok) else $error("overflow on invalid date");

	a_bad_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.date_ok) |-> (rsp.out_day == item_q.in_day &&
		rsp.out_month == item_q.in_month && rsp.out_year == item_q.in_year))
		else $error("invalid date not echoed");

endmodule
